/* hw/rtl/hex_text_message_queue_framer_assert.svh */
// assertion macros for the hex text message queue framer
`ifndef HEX_TEXT_MESSAGE_QUEUE_FRAMER_ASSERT_SVH
`define HEX_TEXT_MESSAGE_QUEUE_FRAMER_ASSERT_SVH

// property must hold at every clock edge out of reset
`define HTMQF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true
`define HTMQF_ASSERT_NEVER(lbl, expr, msg) \
  `HTMQF_ASSERT(lbl, !(expr), msg)

`endif

/* hw/rtl/htmqf_pkg.sv */
// shared types, constants and helper functions of the hex text message queue framer
package htmqf_pkg;

  localparam int unsigned IDX_W = 6;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  localparam logic [7:0]       SEQ_FLAG  = 8'h40;
  localparam logic [7:0]       LEN_CLAMP = 8'd32;
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_SEQ   = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_LEN   = IDX_W'(7);
  localparam logic [IDX_W-1:0] LEN_BIAS  = IDX_W'(7);
  localparam logic [IDX_W-1:0] IDLE_LAST = IDX_W'(8);

  typedef struct packed {
    logic clear_step;
    logic take_char;
    logic frame_begin;
    logic len_load;
    logic stream_step;
    logic sum_emit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic queue_empty;
    logic stream_last;
  } stat_t;

  function automatic logic [3:0] hex_nibble(logic [7:0] ch);
    logic [7:0] diff;
    diff = 8'h00;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      diff = ch - CH_ZERO;
    end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
      diff = ch - CH_UPPER_A + 8'd10;
    end
    return diff[3:0];
  endfunction

  // idle frame bytes; the sequence byte is filled in by the datapath
  function automatic logic [7:0] idle_byte(logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h07;
      4'd2:    b = 8'h1E;
      4'd3:    b = 8'hFB;
      4'd5:    b = 8'h40;
      4'd6:    b = 8'h00;
      4'd7:    b = 8'h01;
      4'd8:    b = 8'h08;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/htmqf_ram.sv */
// generic single write port, single read port ram with registered read
module htmqf_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 1280,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/htmqf_ctrl.sv */
// controller state machine of the hex text message queue framer
module htmqf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 kind_i,
  input  htmqf_pkg::stat_t     stat_i,
  output htmqf_pkg::cmd_t      cmd_o,
  output logic                 busy,
  output logic                 result_strobe_o
);
  import htmqf_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LEN    = 3'd2;
  localparam logic [2:0] ST_STREAM = 3'd3;
  localparam logic [2:0] ST_SUM    = 3'd4;

  logic [2:0] state_q, state_d;
  cmd_t       cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (kind_i) begin
            cmd.frame_begin = 1'b1;
            state_d = stat_i.queue_empty ? ST_STREAM : ST_LEN;
          end else begin
            cmd.take_char = 1'b1;
          end
        end
      end
      ST_LEN: begin
        cmd.len_load = 1'b1;
        state_d = ST_STREAM;
      end
      ST_STREAM: begin
        cmd.stream_step = 1'b1;
        if (stat_i.stream_last) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum_emit = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o           = cmd;
  assign busy            = (state_q != ST_IDLE);
  assign result_strobe_o = cmd.stream_step | cmd.sum_emit;

endmodule

/* hw/rtl/htmqf_dpath.sv */
// datapath of the hex text message queue framer: message store, pointers and frame builder
module htmqf_dpath #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned MSG_BYTES   = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  htmqf_pkg::cmd_t  cmd_i,
  input  logic [7:0]       char_code_i,
  input  logic             buffer_end_i,
  output htmqf_pkg::stat_t stat_o,
  output logic [7:0]       frame_byte_o,
  output logic             frame_last_o,
  output logic             from_queue_o
);
  import htmqf_pkg::*;

  localparam int unsigned DEPTH = QUEUE_DEPTH * MSG_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW    = $clog2(MSG_BYTES + 1);

  localparam logic [AW-1:0]    ADDR_LAST = AW'(DEPTH - 1);
  localparam logic [AW-1:0]    MB_ADDR   = AW'(MSG_BYTES);
  localparam logic [SW-1:0]    SLOT_LAST = SW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0]    QD_CNT    = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0]    MB_POS    = PW'(MSG_BYTES);
  localparam logic [IDX_W-1:0] MB_IDX    = IDX_W'(MSG_BYTES);

  logic [AW-1:0]    clr_addr_q;
  logic [SW-1:0]    wr_slot_q, rd_slot_q;
  logic [CW-1:0]    count_q;
  logic [PW-1:0]    pos_q;
  logic [7:0]       nib_q, frame_cnt_q, sum_q;
  logic [IDX_W-1:0] out_idx_q, last_idx_q;
  logic             from_q_q, b0_zero_q;

  logic             delim, close_byte, close_msg, not_full, pos_room;
  logic [7:0]       nib_new, len_clamped, stream_byte, seq_byte;
  logic [IDX_W-1:0] rd_idx, rd_idx_safe;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr, char_addr;
  logic [7:0]       ram_wdata, ram_rdata;

  // text character decode
  assign delim      = (char_code_i == CH_SPACE) || (char_code_i == CH_NEWLINE);
  assign nib_new    = delim ? nib_q : {nib_q[3:0], hex_nibble(char_code_i)};
  assign close_byte = delim | buffer_end_i;
  assign close_msg  = (char_code_i == CH_NEWLINE) | buffer_end_i;
  assign not_full   = (count_q != QD_CNT);
  assign pos_room   = (pos_q < MB_POS);
  assign char_addr  = AW'(wr_slot_q) * MB_ADDR + AW'(pos_q);

  assign ram_we    = cmd_i.clear_step | (cmd_i.take_char & close_byte & not_full & pos_room);
  assign ram_waddr = cmd_i.clear_step ? clr_addr_q : char_addr;
  assign ram_wdata = cmd_i.clear_step ? 8'h00 : nib_new;

  // read side: length byte first, then the slot bytes in order
  always_comb begin
    if (cmd_i.frame_begin) begin
      rd_idx = IDX_LEN;
    end else if (cmd_i.len_load) begin
      rd_idx = IDX_FIRST;
    end else begin
      rd_idx = out_idx_q + IDX_W'(1);
    end
  end
  assign rd_idx_safe = (rd_idx < MB_IDX) ? rd_idx : IDX_FIRST;
  assign ram_raddr   = AW'(rd_slot_q) * MB_ADDR + AW'(rd_idx_safe);

  htmqf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign len_clamped = (ram_rdata > LEN_CLAMP) ? LEN_CLAMP : ram_rdata;
  assign seq_byte    = from_q_q ? (frame_cnt_q | (b0_zero_q ? SEQ_FLAG : 8'h00)) : frame_cnt_q;

  always_comb begin
    if (out_idx_q == IDX_SEQ) begin
      stream_byte = seq_byte;
    end else if (!from_q_q) begin
      stream_byte = idle_byte(out_idx_q[3:0]);
    end else if (out_idx_q >= MB_IDX) begin
      stream_byte = 8'h00;
    end else begin
      stream_byte = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      wr_slot_q   <= '0;
      rd_slot_q   <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      nib_q       <= '0;
      frame_cnt_q <= '0;
      sum_q       <= '0;
      out_idx_q   <= '0;
      last_idx_q  <= '0;
      from_q_q    <= 1'b0;
      b0_zero_q   <= 1'b0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (cmd_i.take_char) begin
        if (close_byte) begin
          nib_q <= 8'h00;
          if (close_msg) begin
            pos_q <= '0;
            if (not_full) begin
              wr_slot_q <= (wr_slot_q == SLOT_LAST) ? '0 : wr_slot_q + SW'(1);
              count_q   <= count_q + CW'(1);
            end
          end else if (pos_room) begin
            pos_q <= pos_q + PW'(1);
          end
        end else begin
          nib_q <= nib_new;
        end
      end
      if (cmd_i.frame_begin) begin
        frame_cnt_q <= frame_cnt_q + 8'd1;
        from_q_q    <= (count_q != '0);
        sum_q       <= 8'h00;
        out_idx_q   <= IDX_FIRST;
        last_idx_q  <= IDLE_LAST;
      end
      if (cmd_i.len_load) begin
        last_idx_q <= len_clamped[IDX_W-1:0] + LEN_BIAS;
      end
      if (cmd_i.stream_step) begin
        sum_q     <= sum_q + stream_byte;
        out_idx_q <= out_idx_q + IDX_W'(1);
        if (out_idx_q == IDX_FIRST) begin
          b0_zero_q <= (ram_rdata == 8'h00);
        end
      end
      if (cmd_i.sum_emit && from_q_q) begin
        rd_slot_q <= (rd_slot_q == SLOT_LAST) ? '0 : rd_slot_q + SW'(1);
        count_q   <= count_q - CW'(1);
      end
    end
  end

  assign stat_o.clear_done  = (clr_addr_q == ADDR_LAST);
  assign stat_o.queue_empty = (count_q == '0);
  assign stat_o.stream_last = (out_idx_q == last_idx_q);

  assign frame_byte_o = cmd_i.sum_emit ? sum_q : stream_byte;
  assign frame_last_o = cmd_i.sum_emit;
  assign from_queue_o = from_q_q;

endmodule

/* hw/rtl/hex_text_message_queue_framer.sv */
// top level of the hex text message queue framer
//
//  channel  | handshake                 | transfer at rising edge
//  ---------+---------------------------+-------------------------------
//  input    | start, busy               | start high and busy low
//  result   | result_strobe_o           | every cycle with strobe high
//
// a text character leaves busy low, so one may follow each cycle
// a queued frame keeps busy high for the length read, L+8 data bytes and one checksum
// byte (L = clamped length byte); an idle frame keeps busy high for nine data bytes
// and one checksum byte; the store read port sets the pace
// after reset the store is cleared one byte a cycle, all QUEUE_DEPTH*MSG_BYTES bytes,
// with busy high; the receiver cannot stall, a result is shown for one cycle only
module hex_text_message_queue_framer #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned MSG_BYTES   = 40
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       kind_i,
  input  logic [7:0] char_code_i,
  input  logic       buffer_end_i,
  output logic       result_strobe_o,
  output logic [7:0] frame_byte_o,
  output logic       frame_last_o,
  output logic       from_queue_o
);
  import htmqf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  htmqf_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .kind_i          (kind_i),
    .stat_i          (stat),
    .cmd_o           (cmd),
    .busy            (busy),
    .result_strobe_o (result_strobe_o)
  );

  htmqf_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MSG_BYTES   (MSG_BYTES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .char_code_i  (char_code_i),
    .buffer_end_i (buffer_end_i),
    .stat_o       (stat),
    .frame_byte_o (frame_byte_o),
    .frame_last_o (frame_last_o),
    .from_queue_o (from_queue_o)
  );

`include "hex_text_message_queue_framer_assert.svh"

  `HTMQF_ASSERT(a_strobe_busy, result_strobe_o |-> busy, "result outside a frame")
  `HTMQF_ASSERT(a_last_ends, (result_strobe_o && frame_last_o) |=> !busy, "frame end not idle")
  `HTMQF_ASSERT(a_request_busy, (start && !busy && kind_i) |=> busy, "request did not start")
  `HTMQF_ASSERT_NEVER(a_char_quiet, $past(start && !busy && !kind_i) && result_strobe_o, "char made result")

endmodule

/* bench/tb_hex_text_message_queue_framer.sv */
// testbench for hex_text_message_queue_framer: hex text and frame requests checked against a predictor
module tb_hex_text_message_queue_framer;
  import htmqf_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = 32;
  localparam int unsigned MSG_BYTES    = 40;
  localparam logic        KIND_CHAR    = 1'b0;
  localparam logic        KIND_FRAME   = 1'b1;
  localparam int unsigned IDLE_PCT     = 21;
  localparam int unsigned RANDOM_ITEMS = 330;
  localparam int unsigned SETTLE_CYC   = 50;
  localparam longint      RUN_LIMIT    = 3_000_000;
  localparam logic [7:0]  IDLE_FRAME [9] = '{8'h00, 8'h07, 8'h1E, 8'hFB, 8'h00,
                                             8'h40, 8'h00, 8'h01, 8'h08};

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       kind_i;
  logic [7:0] char_code_i;
  logic       buffer_end_i;
  logic       result_strobe_o;
  logic [7:0] frame_byte_o;
  logic       frame_last_o;
  logic       from_queue_o;

  class frame_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       queued;
    } frame_byte_t;

    logic [7:0]  slot_bytes [QUEUE_DEPTH*MSG_BYTES];
    int unsigned wr_slot;
    int unsigned rd_slot;
    int unsigned queued;
    int unsigned pos;
    logic [7:0]  acc;
    logic [7:0]  frame_count;
    frame_byte_t expected_bytes [$];
    int unsigned errors;

    function new();
      foreach (slot_bytes[i]) slot_bytes[i] = 8'h00;
      wr_slot     = 0;
      rd_slot     = 0;
      queued      = 0;
      pos         = 0;
      acc         = 8'h00;
      frame_count = 8'h00;
      errors      = 0;
    endfunction

    function logic [3:0] digit_value(logic [7:0] ch);
      if (ch >= CH_ZERO && ch <= CH_NINE) return ch[3:0];
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) return ch[3:0] + 4'd9;
      return 4'h0;
    endfunction

    function void take_char(logic [7:0] ch, logic last_char);
      logic delim;
      delim = (ch == CH_SPACE) || (ch == CH_NEWLINE);
      if (!delim) acc = {acc[3:0], digit_value(ch)};
      if (delim || last_char) begin
        if (queued < QUEUE_DEPTH && pos < MSG_BYTES) slot_bytes[wr_slot*MSG_BYTES + pos] = acc;
        if (pos < MSG_BYTES) pos++;
        acc = 8'h00;
        if (ch == CH_NEWLINE || last_char) begin
          if (queued < QUEUE_DEPTH) begin
            wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
            queued++;
          end
          pos = 0;
        end
      end
    endfunction

    function void push_byte(logic [7:0] b, logic last, logic q, inout logic [7:0] sum);
      frame_byte_t fb;
      fb.data   = b;
      fb.last   = last;
      fb.queued = q;
      expected_bytes.push_back(fb);
      sum = sum + b;
    endfunction

    function void build_frame();
      logic [7:0]  sum;
      logic [7:0]  b;
      int unsigned base;
      int unsigned len;
      frame_count = frame_count + 8'd1;
      sum = 8'h00;
      if (queued > 0) begin
        base = rd_slot * MSG_BYTES;
        len  = slot_bytes[base + 7];
        if (len > LEN_CLAMP) len = LEN_CLAMP;
        for (int unsigned i = 0; i <= len + 7; i++) begin
          if (i == 4) b = (slot_bytes[base] == 8'h00) ? (frame_count | SEQ_FLAG) : frame_count;
          else b = (i < MSG_BYTES) ? slot_bytes[base + i] : 8'h00;
          push_byte(b, 1'b0, 1'b1, sum);
        end
        push_byte(sum, 1'b1, 1'b1, sum);
        rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
        queued--;
      end else begin
        for (int unsigned i = 0; i < 9; i++) begin
          b = (i == 4) ? frame_count : IDLE_FRAME[i];
          push_byte(b, 1'b0, 1'b0, sum);
        end
        push_byte(sum, 1'b1, 1'b0, sum);
      end
    endfunction

    function void note_item(logic k, logic [7:0] ch, logic last_char);
      if (k == KIND_CHAR) take_char(ch, last_char);
      else build_frame();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_frame_byte(logic [7:0] d, logic l, logic q);
      frame_byte_t fb;
      if (expected_bytes.size() == 0) begin
        flag($sformatf("unexpected frame byte %02h last %0b queue %0b", d, l, q));
        return;
      end
      fb = expected_bytes.pop_front();
      if (d !== fb.data || l !== fb.last || q !== fb.queued)
        flag($sformatf("expected byte %02h last %0b queue %0b, got byte %02h last %0b queue %0b",
                       fb.data, fb.last, fb.queued, d, l, q));
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  frame_scoreboard sb = new();
  int unsigned     sent;
  bit              start_low;

  hex_text_message_queue_framer #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MSG_BYTES  (MSG_BYTES)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .char_code_i    (char_code_i),
    .buffer_end_i   (buffer_end_i),
    .result_strobe_o(result_strobe_o),
    .frame_byte_o   (frame_byte_o),
    .frame_last_o   (frame_last_o),
    .from_queue_o   (from_queue_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #RUN_LIMIT;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_strobe_o) sb.check_frame_byte(frame_byte_o, frame_last_o, from_queue_o);
      if (start && !busy) sb.note_item(kind_i, char_code_i, buffer_end_i);
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? CH_ZERO + 8'(n) : CH_UPPER_A + 8'(n) - 8'd10;
  endfunction

  task automatic lower_start();
    if (!start_low) begin
      start     <= 1'b0;
      start_low = 1'b1;
    end
  endtask

  task automatic send_item(input logic k, input logic [7:0] ch, input logic last_char);
    start        <= 1'b1;
    start_low    = 1'b0;
    kind_i       <= k;
    char_code_i  <= ch;
    buffer_end_i <= last_char;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
    // no idling in this stretch
    if (!(sent >= 150 && sent < 230) && $urandom_range(0, 99) < IDLE_PCT) begin
      lower_start();
      @(posedge clk_i);
      while ($urandom_range(0, 99) < IDLE_PCT) @(posedge clk_i);
    end
  endtask

  task automatic request_frame();
    send_item(KIND_FRAME, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(KIND_CHAR, s[i], 1'b0);
  endtask

  task automatic wait_drained();
    lower_start();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_message(input int unsigned nbytes);
    logic [7:0]  chars [$];
    logic [7:0]  v;
    logic [7:0]  c;
    int unsigned nd;
    int unsigned style;
    bit          mark_end;
    mark_end = 1'b0;
    style    = $urandom_range(0, 2);
    for (int unsigned b = 0; b < nbytes; b++) begin
      // length byte mostly small to keep frames short
      v = (b == 7 && $urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 12)) : 8'($urandom);
      case ($urandom_range(0, 9))
        0:       nd = 1;
        1:       nd = 3;
        2:       nd = 0;
        default: nd = 2;
      endcase
      for (int d = nd; d > 0; d--) begin
        c = hex_char((d == 3) ? 4'($urandom) : ((d == 2) ? v[7:4] : v[3:0]));
        if (c >= CH_UPPER_A && $urandom_range(0, 15) == 0) c = c + 8'h20;
        chars.push_back(c);
      end
      if (b + 1 < nbytes) chars.push_back(CH_SPACE);
      else if (style == 0 || nd == 0) chars.push_back(CH_NEWLINE);
      else if (style == 1) begin
        chars.push_back(CH_SPACE);
        mark_end = 1'b1;
      end else mark_end = 1'b1;
    end
    foreach (chars[i]) send_item(KIND_CHAR, chars[i], mark_end && i == chars.size() - 1);
  endtask

  initial begin
    int unsigned target;
    int unsigned ep;
    int unsigned sel;
    int unsigned n;
    rst_ni       = 1'b0;
    start        = 1'b0;
    start_low    = 1'b1;
    kind_i       = KIND_CHAR;
    char_code_i  = 8'h00;
    buffer_end_i = 1'b0;
    sent         = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle frame, side fields ignored
    send_item(KIND_FRAME, 8'hFF, 1'b1);
    // lowercase, empty byte, non-hex character
    send_text("0F a9  G7F\n");
    // buffer end on a digit, extreme character codes
    send_item(KIND_CHAR, CH_UPPER_A, 1'b0);
    send_item(KIND_CHAR, CH_UPPER_F, 1'b1);
    send_item(KIND_CHAR, 8'h00, 1'b0);
    send_item(KIND_CHAR, 8'hFF, 1'b1);
    send_item(KIND_CHAR, CH_SPACE, 1'b1);
    send_item(KIND_FRAME, 8'h00, 1'b0);
    repeat (4) request_frame();
    wait_drained();

    target = sent + RANDOM_ITEMS;
    ep     = 0;
    while (sent < target) begin
      // long messages only while there is room left in the item budget
      if (ep % 12 == 4 && sent + 4 * (MSG_BYTES + 4) < target)
        send_message($urandom_range(MSG_BYTES + 1, MSG_BYTES + 4));
      else if (ep % 12 == 7) begin
        // overfill the queue with empty messages
        repeat (QUEUE_DEPTH + 3) send_item(KIND_CHAR, CH_NEWLINE, 1'b0);
      end else if (ep % 12 == 10) begin
        wait_drained();
        n = sb.queued;
        repeat (n + 1) request_frame();
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 45) send_message($urandom_range(1, 10));
        else if (sel < 80) repeat ($urandom_range(1, 3)) request_frame();
        else repeat ($urandom_range(1, 5))
          send_item(KIND_CHAR, 8'($urandom), $urandom_range(0, 7) == 0);
      end
      ep++;
    end

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
